>>> hdl/etpc_pkg.sv
`timescale 1ns / 1ps

package etpc_pkg;

   // Fixed field widths of the item and result channels
   localparam int ANALOG_W = 16;
   localparam int OFFSET_W = 10;
   localparam int START_W  = 10;

   // Channels that take part in recording
   localparam int CHANNEL_COUNT = 4;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_KIND    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MASK    = 2'd3;

   // Item modes
   localparam logic [1:0] MODE_TICK = 2'd0;
   localparam logic [1:0] MODE_ARM  = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;

   // Trigger kinds
   localparam logic [2:0] KIND_NONE   = 3'd0;
   localparam logic [2:0] KIND_A_RISE = 3'd1;
   localparam logic [2:0] KIND_A_FALL = 3'd2;
   localparam logic [2:0] KIND_D_RISE = 3'd3;
   localparam logic [2:0] KIND_D_FALL = 3'd4;

   // Capture phases as reported on the result channel
   localparam logic [1:0] PHASE_IDLE  = 2'd0;
   localparam logic [1:0] PHASE_ARMED = 2'd1;
   localparam logic [1:0] PHASE_REC   = 2'd2;

   typedef struct packed {
      logic [1:0]          mode;
      logic [ANALOG_W-1:0] analog_ch0;
      logic [ANALOG_W-1:0] analog_ch1;
      logic [ANALOG_W-1:0] analog_ch2;
      logic [ANALOG_W-1:0] analog_ch3;
      logic                digital_ch0;
      logic                digital_ch1;
      logic                digital_ch2;
      logic                digital_ch3;
      logic [OFFSET_W-1:0] read_offset;
   } req_payload_type;

   typedef struct packed {
      logic                capture_done;
      logic [1:0]          phase;
      logic [START_W-1:0]  start_index;
      logic [ANALOG_W-1:0] read_analog;
      logic                read_digital;
   } rsp_payload_type;

endpackage

>>> hdl/etpc_req_if.sv
`timescale 1ns / 1ps

interface etpc_req_if;
   import etpc_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/etpc_rsp_if.sv
`timescale 1ns / 1ps

interface etpc_rsp_if;
   import etpc_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/edge_triggered_pretrigger_capture.sv
`timescale 1ns / 1ps

// Logic analyser style capture with a pre-trigger ring.
// req_chan carries items: sample ticks, arm requests and ring reads. rsp_chan
// returns exactly one result item per request item, in order. csr_* writes the
// trigger kind, watched channel, analog level and channel mask; write it only
// while no item is in flight.
// Execution: on an armed or recording sample tick the execution stage writes
// each enabled channel to the ring in turn, lowest first, one ring write per
// cycle through the single write port of the ring memory (only the last write
// waits while a result is held); arm, read and idle ticks write nothing. The
// result sits in the output register from the cycle after the last step, and
// the next item can be accepted in the cycle that the current one finishes.
// The output register parts the two sides: a new item is accepted while a
// result waits; when the receiver stalls, execution stops at its last step.
// Reset clears configuration, phase, pointers and the fill count. The ring
// itself needs no clearing pass: writes only ever run upwards from entry zero,
// so a fill count marks the written entries and any entry beyond it reads as
// zero.
module edge_triggered_pretrigger_capture #(
   parameter int RING_DEPTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   etpc_req_if.sink                             req_chan,
   etpc_rsp_if.source                           rsp_chan,
   input  logic                                 csr_wr_en,
   input  logic [etpc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [etpc_pkg::CSR_DATA_W-1:0]      csr_wr_data
);
   import etpc_pkg::*;

   localparam int IDX_W  = $clog2(RING_DEPTH);
   localparam int CNT_W  = IDX_W + 1;
   localparam int SUM_W  = ((IDX_W > OFFSET_W) ? IDX_W : OFFSET_W) + 1;
   localparam int HALF   = RING_DEPTH / 2;
   localparam int WORD_W = ANALOG_W + 1;
   localparam logic [3:0] CHAN_EN = 4'((1 << CHANNEL_COUNT) - 1);

   // number of shifted-depth subtractions needed to reduce a read offset
   function automatic int count_steps();
      int n;
      n = 0;
      for (int k = 0; k < OFFSET_W; k++) begin
         if ((RING_DEPTH << k) <= ((1 << OFFSET_W) - 1)) begin
            n++;
         end
      end
      return n;
   endfunction

   localparam int OFF_STEPS = count_steps();

   // offset modulo ring depth, restoring style
   function automatic logic [OFFSET_W-1:0] reduce_offset(input logic [OFFSET_W-1:0] off);
      logic [OFFSET_W-1:0] r;
      r = off;
      for (int k = OFFSET_W - 1; k >= 0; k--) begin
         if (k < OFF_STEPS) begin
            if (r >= OFFSET_W'(RING_DEPTH << k)) begin
               r = r - OFFSET_W'(RING_DEPTH << k);
            end
         end
      end
      return r;
   endfunction

   // configuration registers
   logic [2:0]          kind_ff;
   logic [1:0]          chan_ff;
   logic [ANALOG_W-1:0] level_ff;
   logic [3:0]          mask_ff;

   // capture state
   logic [1:0]          phase_ff, phase_in;
   logic [IDX_W-1:0]    wi_ff, wi_in;
   logic [IDX_W-1:0]    start_ff, start_in;
   logic [IDX_W-1:0]    rem_ff, rem_in;
   logic [ANALOG_W-1:0] prev_a_ff, prev_a_in;
   logic                prev_d_ff, prev_d_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;

   // execution stage
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_first_ff, s1_first_in;
   logic [3:0]          pend_ff, pend_in;
   req_payload_type     s1_item_ff;

   // output register
   logic                s2_valid_ff, s2_valid_in;
   logic                s2_done_ff, s2_done_in;
   logic [1:0]          s2_phase_ff, s2_phase_in;
   logic [START_W-1:0]  s2_start_ff, s2_start_in;
   logic                s2_rd_ff, s2_rd_in;

   // working signals
   logic                accept, s2_take, advance, finish, last, write_now;
   logic [3:0]          pend_init, pend_cur;
   logic [1:0]          ch_sel;
   logic [ANALOG_W-1:0] wr_analog, cur_a;
   logic                wr_digital, cur_d;
   logic                kind_ok, hit;
   logic [2:0]          n_en;
   logic [IDX_W-1:0]    wi_inc, wi_after, rem_sub;
   logic [CNT_W-1:0]    trig_sum, wi_next_cnt;
   logic [OFFSET_W-1:0] off_red;
   logic [SUM_W-1:0]    pos_sum, pos_wrap, start_ext;
   logic                rd_en, rd_hit;
   logic [WORD_W-1:0]   ram_rdata;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= KIND_NONE;
         chan_ff  <= '0;
         level_ff <= '0;
         mask_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_KIND:    kind_ff  <= csr_wr_data[2:0];
            CSR_CHANNEL: chan_ff  <= csr_wr_data[1:0];
            CSR_LEVEL:   level_ff <= csr_wr_data[ANALOG_W-1:0];
            CSR_MASK:    mask_ff  <= csr_wr_data[3:0];
         endcase
      end
   end

   // watched channel of the item in execution
   always_comb begin
      unique case (chan_ff)
         2'd0: begin cur_a = s1_item_ff.analog_ch0; cur_d = s1_item_ff.digital_ch0; end
         2'd1: begin cur_a = s1_item_ff.analog_ch1; cur_d = s1_item_ff.digital_ch1; end
         2'd2: begin cur_a = s1_item_ff.analog_ch2; cur_d = s1_item_ff.digital_ch2; end
         2'd3: begin cur_a = s1_item_ff.analog_ch3; cur_d = s1_item_ff.digital_ch3; end
      endcase
   end

   // channel written this cycle
   always_comb begin
      unique case (ch_sel)
         2'd0: begin wr_analog = s1_item_ff.analog_ch0; wr_digital = s1_item_ff.digital_ch0; end
         2'd1: begin wr_analog = s1_item_ff.analog_ch1; wr_digital = s1_item_ff.digital_ch1; end
         2'd2: begin wr_analog = s1_item_ff.analog_ch2; wr_digital = s1_item_ff.digital_ch2; end
         2'd3: begin wr_analog = s1_item_ff.analog_ch3; wr_digital = s1_item_ff.digital_ch3; end
      endcase
   end

   always_comb begin
      // channels still to be written for this tick
      if (s1_item_ff.mode == MODE_TICK &&
          (phase_ff == PHASE_ARMED || phase_ff == PHASE_REC)) begin
         pend_init = mask_ff & CHAN_EN;
      end else begin
         pend_init = '0;
      end
      pend_cur = s1_first_ff ? pend_init : pend_ff;
      last     = (pend_cur & (pend_cur - 4'd1)) == 4'd0;

      // pick the lowest pending channel
      ch_sel = '0;
      for (int c = 3; c >= 0; c--) begin
         if (pend_cur[c]) begin
            ch_sel = 2'(c);
         end
      end

      n_en = '0;
      for (int c = 0; c < 4; c++) begin
         n_en = n_en + 3'((mask_ff & CHAN_EN) >> c & 4'd1);
      end

      s2_take   = !s2_valid_ff || rsp_chan.ready;
      advance   = s1_valid_ff && (!last || s2_take);
      finish    = advance && last;
      write_now = advance && (pend_cur != 4'd0);
      accept    = req_chan.valid && (!s1_valid_ff || finish);

      wi_inc   = (wi_ff == IDX_W'(RING_DEPTH - 1)) ? '0 : wi_ff + IDX_W'(1);
      wi_after = write_now ? wi_inc : wi_ff;

      // trigger test against the live configuration
      kind_ok = (kind_ff != KIND_NONE) && (kind_ff <= KIND_D_FALL);
      unique case (kind_ff)
         KIND_A_RISE: hit = (prev_a_ff < level_ff) && (cur_a >= level_ff);
         KIND_A_FALL: hit = (prev_a_ff > level_ff) && (cur_a <= level_ff);
         KIND_D_RISE: hit = !prev_d_ff && cur_d;
         KIND_D_FALL: hit = prev_d_ff && !cur_d;
         default:     hit = 1'b0;
      endcase

      trig_sum = CNT_W'(wi_after) + CNT_W'(HALF);
      if (trig_sum >= CNT_W'(RING_DEPTH)) begin
         trig_sum = trig_sum - CNT_W'(RING_DEPTH);
      end

      rem_sub = (rem_ff > IDX_W'(n_en)) ? rem_ff - IDX_W'(n_en) : '0;

      // read position in time order from the capture start
      off_red = reduce_offset(s1_item_ff.read_offset);
      pos_sum = SUM_W'(start_ff) + SUM_W'(off_red);
      pos_wrap = (pos_sum >= SUM_W'(RING_DEPTH)) ? pos_sum - SUM_W'(RING_DEPTH) : pos_sum;
      rd_hit  = pos_wrap < SUM_W'(fill_ff);
      rd_en   = finish && (s1_item_ff.mode == MODE_READ);

      wi_next_cnt = CNT_W'(wi_ff) + CNT_W'(1);

      // defaults: hold
      phase_in  = phase_ff;
      wi_in     = wi_ff;
      start_in  = start_ff;
      rem_in    = rem_ff;
      prev_a_in = prev_a_ff;
      prev_d_in = prev_d_ff;
      fill_in   = fill_ff;
      pend_in   = pend_ff;
      s2_done_in = 1'b0;

      if (write_now) begin
         wi_in = wi_inc;
         if (wi_next_cnt > fill_ff) begin
            fill_in = wi_next_cnt;
         end
      end
      if (advance) begin
         pend_in = pend_cur & ~(4'd1 << ch_sel);
      end

      if (finish) begin
         unique case (s1_item_ff.mode)
            MODE_ARM: begin
               prev_a_in = cur_a;
               prev_d_in = cur_d;
               phase_in  = kind_ok ? PHASE_ARMED : PHASE_IDLE;
            end
            MODE_TICK: begin
               if (phase_ff == PHASE_ARMED && kind_ok) begin
                  if (hit) begin
                     start_in = trig_sum[IDX_W-1:0];
                     rem_in   = IDX_W'(HALF);
                     phase_in = PHASE_REC;
                  end else if (kind_ff <= KIND_A_FALL) begin
                     prev_a_in = cur_a;
                  end else begin
                     prev_d_in = cur_d;
                  end
               end else if (phase_ff == PHASE_REC) begin
                  rem_in = rem_sub;
                  if (rem_sub == '0) begin
                     s2_done_in = 1'b1;
                     phase_in   = PHASE_IDLE;
                     wi_in      = '0;
                  end
               end
            end
            default: begin
               // reads and unused modes leave the state alone
            end
         endcase
      end

      start_ext   = SUM_W'(start_in);
      s2_phase_in = phase_in;
      s2_start_in = start_ext[START_W-1:0];
      s2_rd_in    = rd_en && rd_hit;

      s1_valid_in = accept ? 1'b1 : (finish ? 1'b0 : s1_valid_ff);
      s1_first_in = accept ? 1'b1 : (advance ? 1'b0 : s1_first_ff);
      s2_valid_in = finish ? 1'b1 : (rsp_chan.ready ? 1'b0 : s2_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_IDLE;
         wi_ff       <= '0;
         start_ff    <= '0;
         rem_ff      <= '0;
         prev_a_ff   <= '0;
         prev_d_ff   <= 1'b0;
         fill_ff     <= '0;
         pend_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s1_first_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         wi_ff       <= wi_in;
         start_ff    <= start_in;
         rem_ff      <= rem_in;
         prev_a_ff   <= prev_a_in;
         prev_d_ff   <= prev_d_in;
         fill_ff     <= fill_in;
         pend_ff     <= pend_in;
         s1_valid_ff <= s1_valid_in;
         s1_first_ff <= s1_first_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_chan.payload;
      end
      if (finish) begin
         s2_done_ff  <= s2_done_in;
         s2_phase_ff <= s2_phase_in;
         s2_start_ff <= s2_start_in;
         s2_rd_ff    <= s2_rd_in;
      end
   end

   // ring of {analog, digital} entries
   etpc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (write_now),
      .wr_addr (wi_ff),
      .wr_data ({wr_analog, wr_digital}),
      .rd_en   (rd_en),
      .rd_addr (pos_wrap[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   assign req_chan.ready = !s1_valid_ff || finish;

   assign rsp_chan.valid                = s2_valid_ff;
   assign rsp_chan.payload.capture_done = s2_done_ff;
   assign rsp_chan.payload.phase        = s2_phase_ff;
   assign rsp_chan.payload.start_index  = s2_start_ff;
   assign rsp_chan.payload.read_analog  = s2_rd_ff ? ram_rdata[WORD_W-1:1] : '0;
   assign rsp_chan.payload.read_digital = s2_rd_ff & ram_rdata[0];

endmodule

>>> hdl/etpc_ram.sv
`timescale 1ns / 1ps

module etpc_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // hold the last read word until the next read
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
